### rtl/nss_pkg.sv
package nss_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned PROD_W = WORD_W + 3;

  // largest 7-smooth number below 2^32 (2 * 3^6 * 5^2 * 7^6)
  localparam logic [WORD_W-1:0] SMOOTH_CAP = 32'd4288306050;

  // full-length word, a normalised mantissa of this length is exact
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(WORD_W);

  // factor select for the shared scaling unit
  localparam logic [1:0] MUL3 = 2'd0;
  localparam logic [1:0] MUL5 = 2'd1;
  localparam logic [1:0] MUL7 = 2'd2;

  // value = mant * 2^(len - WORD_W), mant has its top bit set
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] mant;
  } num_t;

  // strict less-than on normalised numbers
  function automatic logic num_lt(input num_t a, input num_t b);
    logic r;
    if (a.len != b.len) begin
      r = (a.len < b.len);
    end else begin
      r = (a.mant < b.mant);
    end
    return r;
  endfunction

endpackage

### rtl/nss_scale.sv
module nss_scale
  import nss_pkg::*;
(
  input  num_t       a,
  input  logic [1:0] sel,
  output num_t       y
);

  logic [PROD_W-1:0] prod;

  always_comb begin
    case (sel)
      MUL3: prod = {3'b000, a.mant} + {2'b00, a.mant, 1'b0};
      MUL5: prod = {3'b000, a.mant} + {1'b0, a.mant, 2'b00};
      MUL7: prod = {a.mant, 3'b000} - {3'b000, a.mant};
      default: prod = {3'b000, a.mant};
    endcase
  end

  // renormalise: the product grows by one to three bits
  always_comb begin
    if (prod[PROD_W-1]) begin
      y.mant = prod[PROD_W-1:3];
      y.len  = a.len + LEN_W'(3);
    end else if (prod[PROD_W-2]) begin
      y.mant = prod[PROD_W-2:2];
      y.len  = a.len + LEN_W'(2);
    end else begin
      y.mant = prod[PROD_W-3:1];
      y.len  = a.len + LEN_W'(1);
    end
  end

endmodule

### rtl/nss_cand.sv
module nss_cand
  import nss_pkg::*;
(
  input  num_t p,
  input  num_t m,
  input  num_t best,
  output logic p_below,
  output logic improve,
  output num_t cand
);

  // smallest p * 2^k that is at least m
  always_comb begin
    cand.mant = p.mant;
    if (p.len > m.len) begin
      cand.len = p.len;
    end else if (p.mant >= m.mant) begin
      cand.len = m.len;
    end else begin
      cand.len = m.len + LEN_W'(1);
    end
  end

  assign p_below = num_lt(p, best);
  assign improve = num_lt(cand, best);

endmodule

### rtl/next_seven_smooth_size.sv
// next_seven_smooth_size
//
// Returns, for each 32-bit count on the input stream, the smallest number
// above it with no prime factor other than 2, 3, 5 and 7 (n = 0 gives 1).
// A count at or above 4288306050 returns 0 with the too_large flag set.
//
// Channels: in_* carries the count, out_* the result; an item moves when
// tvalid and tready are both high at a rising edge of clk.
//
// Flow: one item at a time. count+1 is first normalised by shifting it
// left; the odd products 3^a*5^b*7^c below the best so far then go
// through one shared scale-by-3/5/7 unit, one per cycle, stepping through
// the 5 and 7 levels when a run of powers of 3 ends; the best is then
// shifted back down to an integer and handed over. Too large: straight
// to the hand-over.
//
// in_tready is high only while idle; a result waiting in the output
// register does not block acceptance of the next item, but a finished
// result holds in the shift-back state until the output register is free.
// Reset (rst_n low, synchronous) drops any item in flight and the output.
module next_seven_smooth_size
  import nss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [WORD_W-1:0] in_tdata,   // [31:0] count_in
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata,  // [31:0] next_size
  output logic              out_tuser   // [0] too_large
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_NORM   = 3'd1;
  localparam logic [2:0] ST_SCAN3  = 3'd2;
  localparam logic [2:0] ST_SCAN5  = 3'd3;
  localparam logic [2:0] ST_SCAN7  = 3'd4;
  localparam logic [2:0] ST_DENORM = 3'd5;

  localparam num_t ONE_N = '{len: LEN_W'(1), mant: {1'b1, {(WORD_W-1){1'b0}}}};

  logic [2:0] state_r, state_nxt;

  // m: count+1 normalised; p3/p5/p7: current product at each loop level
  num_t m_r, m_nxt;
  num_t best_r, best_nxt;
  num_t p3_r, p3_nxt;
  num_t p5_r, p5_nxt;
  num_t p7_r, p7_nxt;
  logic too_r, too_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt;

  logic in_acc;
  logic slot_free;

  // shared scaling unit
  num_t       scl_a;
  logic [1:0] scl_sel;
  num_t       scl_y;

  nss_scale u_scale (
    .a   (scl_a),
    .sel (scl_sel),
    .y   (scl_y)
  );

  logic p_below;
  logic improve;
  num_t cand;

  nss_cand u_cand (
    .p       (p3_r),
    .m       (m_r),
    .best    (best_r),
    .p_below (p_below),
    .improve (improve),
    .cand    (cand)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    case (state_r)
      ST_SCAN5: begin
        scl_a   = p5_r;
        scl_sel = MUL5;
      end
      ST_SCAN7: begin
        scl_a   = p7_r;
        scl_sel = MUL7;
      end
      default: begin
        scl_a   = p3_r;
        scl_sel = MUL3;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    best_nxt      = best_r;
    p3_nxt        = p3_r;
    p5_nxt        = p5_r;
    p7_nxt        = p7_r;
    too_nxt       = too_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tdata >= SMOOTH_CAP) begin
            too_nxt       = 1'b1;
            best_nxt.len  = LEN_FULL;
            best_nxt.mant = '0;
            state_nxt     = ST_DENORM;
          end else begin
            too_nxt       = 1'b0;
            m_nxt.len     = LEN_FULL;
            m_nxt.mant    = in_tdata + WORD_W'(1);
            best_nxt.len  = LEN_FULL;
            best_nxt.mant = SMOOTH_CAP;
            state_nxt     = ST_NORM;
          end
        end
      end

      ST_NORM: begin
        if (m_r.mant[WORD_W-1]) begin
          p3_nxt    = ONE_N;
          p5_nxt    = ONE_N;
          p7_nxt    = ONE_N;
          state_nxt = ST_SCAN3;
        end else begin
          m_nxt.mant = {m_r.mant[WORD_W-2:0], 1'b0};
          m_nxt.len  = m_r.len - LEN_W'(1);
        end
      end

      // innermost level: try p3, then step it by 3
      ST_SCAN3: begin
        if (p_below) begin
          if (improve) begin
            best_nxt = cand;
          end
          p3_nxt = scl_y;
        end else begin
          state_nxt = ST_SCAN5;
        end
      end

      ST_SCAN5: begin
        if (num_lt(scl_y, best_r)) begin
          p5_nxt    = scl_y;
          p3_nxt    = scl_y;
          state_nxt = ST_SCAN3;
        end else begin
          state_nxt = ST_SCAN7;
        end
      end

      ST_SCAN7: begin
        if (num_lt(scl_y, best_r)) begin
          p7_nxt    = scl_y;
          p5_nxt    = scl_y;
          p3_nxt    = scl_y;
          state_nxt = ST_SCAN3;
        end else begin
          state_nxt = ST_DENORM;
        end
      end

      // shift the mantissa back down to an integer, then hand it over
      ST_DENORM: begin
        if (best_r.len != LEN_FULL) begin
          best_nxt.mant = {1'b0, best_r.mant[WORD_W-1:1]};
          best_nxt.len  = best_r.len + LEN_W'(1);
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = best_r.mant;
          out_user_nxt  = too_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    best_r     <= best_nxt;
    p3_r       <= p3_nxt;
    p5_r       <= p5_nxt;
    p7_r       <= p7_nxt;
    too_r      <= too_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import nss_pkg::*;

  // One expected answer per accepted count.
  typedef struct packed {
    logic [WORD_W-1:0] next_size;
    logic              too_large;
  } size_result_t;

  // A count waiting to go in. When drain_first is set the sender holds it back
  // until every earlier answer has come out.
  typedef struct {
    logic [WORD_W-1:0] count;
    bit                drain_first;
  } count_item_t;

  localparam int unsigned N_RANDOM = 550;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [WORD_W-1:0] in_tdata;   // [31:0] count_in
  logic              out_tvalid;
  logic              out_tready;
  logic [WORD_W-1:0] out_tdata;  // [31:0] next_size
  logic              out_tuser;  // [0] too_large

  count_item_t  count_q[$];      // counts not yet offered to the block
  size_result_t size_exp_q[$];   // answers owed by the block, oldest first

  int unsigned n_total;
  int unsigned n_sent;           // written only by the driver, nonblocking
  int unsigned n_returned;       // written by the monitor (nonblocking) and zeroed at start
  int unsigned n_over_cap;
  int unsigned n_fail;
  int unsigned send_idle_pct;
  int unsigned rcv_idle_pct;

  logic         drv_took;
  int unsigned  drv_sent_now;
  count_item_t  drv_head;
  size_result_t mon_exp;

  next_seven_smooth_size u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  // Smallest number above count with no prime factor beyond 7. Every odd
  // product 3^i*5^j*7^k is doubled until it passes count; the least of those
  // wins. Products already at or above the best so far cannot improve it.
  function automatic size_result_t predict_next_smooth(input logic [WORD_W-1:0] count);
    size_result_t res;
    logic [63:0]  best;
    logic [63:0]  pow7;
    logic [63:0]  pow5;
    logic [63:0]  pow3;
    logic [63:0]  scaled;
    res.too_large = (count >= SMOOTH_CAP);
    res.next_size = '0;
    if (!res.too_large) begin
      best = 64'(SMOOTH_CAP);
      for (pow7 = 64'd1; pow7 < best; pow7 = pow7 * 7) begin
        for (pow5 = pow7; pow5 < best; pow5 = pow5 * 5) begin
          for (pow3 = pow5; pow3 < best; pow3 = pow3 * 3) begin
            scaled = pow3;
            while (scaled <= 64'(count)) scaled = scaled << 1;
            if (scaled < best) best = scaled;
          end
        end
      end
      res.next_size = best[WORD_W-1:0];
    end
    return res;
  endfunction

  // Random 7-smooth value no larger than the cap.
  function automatic logic [63:0] random_smooth();
    logic [63:0] v;
    logic [63:0] f;
    v = 64'd1;
    repeat ($urandom_range(1, 30)) begin
      case ($urandom_range(0, 3))
        0:       f = 64'd2;
        1:       f = 64'd3;
        2:       f = 64'd5;
        default: f = 64'd7;
      endcase
      if (v * f <= 64'(SMOOTH_CAP)) v = v * f;
    end
    return v;
  endfunction

  // Mix of counts: plain random words, counts on either side of smooth
  // numbers (where an off-by-one bites), small counts, counts spread over all
  // magnitudes, and counts around and past the cap.
  function automatic logic [WORD_W-1:0] random_count();
    logic [63:0]       s;
    logic [WORD_W-1:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = $urandom;
      3, 4, 5: begin
        s = random_smooth();
        c = WORD_W'(s - 64'd1 + 64'($urandom_range(0, 2)));
      end
      6:       c = $urandom_range(0, 5000);
      7:       c = $urandom >> $urandom_range(0, 31);
      8:       c = SMOOTH_CAP - 32'd200 + 32'($urandom_range(0, 400));
      default: c = $urandom_range(32'hFFFF_FFFF, SMOOTH_CAP);
    endcase
    return c;
  endfunction

  // Idling schedule over the run: sender light / receiver heavy, then the
  // reverse, then a last third with no idling at all.
  assign send_idle_pct = (n_sent < n_total / 3)     ? 33 :
                         (n_sent < 2 * n_total / 3) ? 66 : 0;
  assign rcv_idle_pct  = (n_sent < n_total / 3)     ? 66 :
                         (n_sent < 2 * n_total / 3) ? 33 : 0;

  // Sender. On acceptance the answer is predicted straight away; a new count
  // is offered only when the slot is free, so tvalid gets one update a step.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      n_sent    <= 0;
    end else begin
      drv_took = in_tvalid && in_tready;
      if (drv_took) size_exp_q.push_back(predict_next_smooth(in_tdata));
      drv_sent_now = n_sent + (drv_took ? 1 : 0);
      n_sent <= drv_sent_now;
      if (!in_tvalid || drv_took) begin
        if (count_q.size() != 0 &&
            !(count_q[0].drain_first && drv_sent_now != n_returned) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          drv_head = count_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= drv_head.count;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Result checker: every accepted result against the oldest owed answer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_returned <= n_returned + 1;
      if (size_exp_q.size() == 0) begin
        $error("unexpected result: next_size %0d too_large %0b", out_tdata, out_tuser);
        n_fail++;
      end else begin
        mon_exp = size_exp_q.pop_front();
        if (mon_exp.too_large) n_over_cap++;
        if (out_tdata !== mon_exp.next_size) begin
          $error("next_size mismatch: expected %0d, got %0d", mon_exp.next_size, out_tdata);
          n_fail++;
        end
        if (out_tuser !== mon_exp.too_large) begin
          $error("too_large mismatch: expected %0b, got %0b", mon_exp.too_large, out_tuser);
          n_fail++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [WORD_W-1:0] directed[$];
    count_item_t       item;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    n_returned = 0;
    n_over_cap = 0;
    n_fail     = 0;

    // Directed: zero (answer 1), tiny counts, counts sitting on smooth
    // numbers, word extremes, alternating bit patterns, and the cap edges
    // (just below gives the cap itself, at or above is too large).
    directed = '{32'd0, 32'd1, 32'd2, 32'd6, 32'd7, 32'd10, 32'd11, 32'd63, 32'd64,
                 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'd4287500000, SMOOTH_CAP - 32'd2, SMOOTH_CAP - 32'd1, SMOOTH_CAP,
                 SMOOTH_CAP + 32'd1, 32'hFFFF_FFFF};
    foreach (directed[i]) begin
      item.count       = directed[i];
      item.drain_first = 1'b0;
      count_q.push_back(item);
    end
    // Random part; the sender drains the block fully before its first item
    // and again halfway through.
    for (int i = 0; i < N_RANDOM; i++) begin
      item.count       = random_count();
      item.drain_first = (i == 0) || (i == N_RANDOM / 2);
      count_q.push_back(item);
    end
    n_total = count_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (count_q.size() != 0 || in_tvalid) @(posedge clk);
    while (n_returned != n_sent) @(posedge clk);
    // Room for any stray result to show up after the last owed one.
    repeat (700) @(posedge clk);

    $display("Checked %0d answers (%0d past the cap) over %0d counts.",
             n_returned, n_over_cap, n_total);
    $display("Stalls swapped sides across three phases, with two full drains mid-run.");
    if (n_fail == 0 && size_exp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (size_exp_q.size() != 0) $error("%0d answers never arrived", size_exp_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: well over three times the slowest legal run.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### next_seven_smooth_size.f
rtl/nss_pkg.sv
rtl/nss_scale.sv
rtl/nss_cand.sv
rtl/next_seven_smooth_size.sv
sim/tb.sv
